/* design/batavg_pkg.sv */
// ----------------------------------------------------------------------------
// batavg_pkg
// shared types and constants of the battery level moving average block
// ----------------------------------------------------------------------------
package batavg_pkg;

   // register indexes of the csr write channel
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE = 2'd1;

   localparam int CODE_W = 12;
   localparam int PCT_W  = 7;
   localparam int SUM_W  = 18;                   // running window sum
   localparam int NUM_W  = SUM_W + PCT_W;        // scaled numerator of percent
   localparam int QUO_W  = 7;                    // widest quotient produced
   localparam int QCNT_W = 4;                    // quotient bit counter

   localparam logic [PCT_W-1:0]  PCT_SCALE    = 7'd100;
   localparam logic [QCNT_W-1:0] QBITS_PCT    = 4'd7;
   localparam logic [QCNT_W-1:0] QBITS_MAX    = 4'd7;

   // divider command
   typedef struct packed {
      logic                start;
      logic [NUM_W-1:0]    dividend;
      logic [SUM_W-1:0]    divisor;
      logic [QCNT_W-1:0]   quo_bits;   // quotient known to fit in this many bits
   } div_req_type;

   // divider result
   typedef struct packed {
      logic                done;
      logic [QUO_W-1:0]    quotient;
   } div_rsp_type;

endpackage

/* design/batavg_ram.sv */
// ----------------------------------------------------------------------------
// batavg_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module batavg_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 20
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/batavg_div.sv */
// ----------------------------------------------------------------------------
// batavg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module batavg_div (
   input  logic                     clock,
   input  logic                     reset,
   input  batavg_pkg::div_req_type  req,
   output batavg_pkg::div_rsp_type  rsp
);

   logic [batavg_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [batavg_pkg::SUM_W-1:0]  dvs_ff, dvs_in;
   logic [batavg_pkg::QUO_W-1:0]  feed_ff, feed_in;
   logic [batavg_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [batavg_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [batavg_pkg::SUM_W:0]    trial;

   // partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, feed_ff[batavg_pkg::QUO_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      feed_in = feed_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         // upper part is below the divisor since the quotient fits quo_bits
         rem_in  = batavg_pkg::SUM_W'(req.dividend >> req.quo_bits);
         feed_in = batavg_pkg::QUO_W'(req.dividend)
                   << (batavg_pkg::QBITS_MAX - req.quo_bits);
         dvs_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = req.quo_bits;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = batavg_pkg::SUM_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[batavg_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = batavg_pkg::SUM_W'(trial);
            quo_in = {quo_ff[batavg_pkg::QUO_W-2:0], 1'b0};
         end
         feed_in = {feed_ff[batavg_pkg::QUO_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == batavg_pkg::QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      feed_ff <= feed_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* design/battery_level_moving_average.sv */
// ----------------------------------------------------------------------------
// battery_level_moving_average
// moving average of battery adc codes mapped to a charge percentage
// ----------------------------------------------------------------------------
// each req transaction carries one 12-bit adc code; each one yields exactly one
// rsp transaction with the charge percent (0..100) and the window average code.
// the last WINDOW codes sit in a small ram with a running sum; the first code
// after reset is written into every ring slot, one slot per cycle. the 7-bit
// percent comes from a single restoring divider, and the average code is a
// reciprocal multiplication by 1/WINDOW. when max_code <= min_code the divider
// is skipped. one item is worked at a time; a new item can be accepted while
// the previous result is still waiting on rsp, and that item then holds in its
// last state until the output register is free. min_code and max_code are
// written through the csr channel, which is always ready; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module battery_level_moving_average #(
   parameter int WINDOW = 20
) (
   input  logic        clock,
   input  logic        reset,
   // input samples
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,      // [11:0] adc_code
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,      // [6:0] percent, [18:7] average_code
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [batavg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [batavg_pkg::CODE_W-1:0]    csr_data
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
   localparam logic [SLOT_W-1:0] SLOT_PRIME = SLOT_W'((WINDOW > 1) ? 1 : 0);
   localparam logic [batavg_pkg::SUM_W-1:0] WIN_SUM = batavg_pkg::SUM_W'(WINDOW);

   // floor(sum / WINDOW) = (sum * AVG_RECIP) >> RECIP_SHIFT, exact for any sum
   localparam int RECIP_SHIFT = batavg_pkg::SUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
   localparam int RECIP_W     = batavg_pkg::SUM_W + 1;
   localparam int PROD_W      = batavg_pkg::SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_PRIME  = 9'b0_0000_0010,   // fill every ring slot with the first code
      ST_READ   = 9'b0_0000_0100,   // ram read of the oldest slot
      ST_UPDATE = 9'b0_0000_1000,   // replace oldest, update sum
      ST_SCALE  = 9'b0_0001_0000,   // bounds, span and window average
      ST_CLAMP  = 9'b0_0010_0000,   // clamp and scale by 100
      ST_PSTART = 9'b0_0100_0000,
      ST_PCT    = 9'b0_1000_0000,
      ST_DONE   = 9'b1_0000_0000    // hand result to the output register
   } state_type;

   state_type state_ff, state_in;

   logic [batavg_pkg::CODE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [batavg_pkg::CODE_W-1:0] code_ff, code_in;
   logic [batavg_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [SLOT_W-1:0]             fill_ff, fill_in;
   logic                          primed_ff, primed_in;
   logic [batavg_pkg::SUM_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, span_ff, span_in;
   logic                          range_ok_ff, range_ok_in;
   logic [batavg_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [batavg_pkg::CODE_W-1:0] avg_ff, avg_in;
   logic [batavg_pkg::PCT_W-1:0]  pct_ff, pct_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [batavg_pkg::PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;
   logic [batavg_pkg::CODE_W-1:0] rsp_avg_ff, rsp_avg_in;

   logic [batavg_pkg::SUM_W-1:0]  clamp_lo, clamped;
   logic [PROD_W-1:0]             avg_prod;
   logic                          ram_wr_en;
   logic [SLOT_W-1:0]             ram_wr_addr;
   logic [batavg_pkg::CODE_W-1:0] ram_rd_data;
   logic                          req_fire;

   batavg_pkg::div_req_type div_req;
   batavg_pkg::div_rsp_type div_rsp;

   // sample ring
   batavg_ram #(
      .WIDTH (batavg_pkg::CODE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (code_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // divider for the percent
   batavg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ram_wr_en   = (state_ff == ST_PRIME) || (state_ff == ST_UPDATE);
   assign ram_wr_addr = (state_ff == ST_PRIME) ? fill_ff : slot_ff;

   // raise to the lower bound first, then lower to the upper bound
   assign clamp_lo = (sum_ff < lo_ff) ? lo_ff : sum_ff;
   assign clamped  = (clamp_lo > hi_ff) ? hi_ff : clamp_lo;

   // window average by reciprocal multiplication
   assign avg_prod = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);

   // divider command: percent in pstart state
   always_comb begin
      div_req.start    = (state_ff == ST_PSTART) && range_ok_ff;
      div_req.dividend = num_ff;
      div_req.divisor  = span_ff;
      div_req.quo_bits = batavg_pkg::QBITS_PCT;
   end

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      code_in      = code_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      primed_in    = primed_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      span_in      = span_ff;
      range_ok_in  = range_ok_ff;
      num_in       = num_ff;
      avg_in       = avg_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pct_in   = rsp_pct_ff;
      rsp_avg_in   = rsp_avg_ff;

      // register writes, indexes past the list are dropped
      if (csr_valid) begin
         case (csr_index)
            batavg_pkg::CSR_MIN_CODE: min_in = csr_data;
            batavg_pkg::CSR_MAX_CODE: max_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               code_in = req_tdata[batavg_pkg::CODE_W-1:0];
               if (primed_ff) begin
                  state_in = ST_READ;
               end else begin
                  sum_in   = '0;
                  fill_in  = '0;
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // sum ends at code * WINDOW, then slot 0 counts as replaced
            sum_in  = sum_ff + batavg_pkg::SUM_W'(code_ff);
            fill_in = fill_ff + 1'b1;
            if (fill_ff == SLOT_LAST) begin
               primed_in = 1'b1;
               slot_in   = SLOT_PRIME;
               state_in  = ST_SCALE;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            sum_in   = sum_ff - batavg_pkg::SUM_W'(ram_rd_data)
                       + batavg_pkg::SUM_W'(code_ff);
            slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            lo_in       = batavg_pkg::SUM_W'(min_ff) * WIN_SUM;
            hi_in       = batavg_pkg::SUM_W'(max_ff) * WIN_SUM;
            span_in     = batavg_pkg::SUM_W'(max_ff - min_ff) * WIN_SUM;
            range_ok_in = (max_ff > min_ff);
            avg_in      = batavg_pkg::CODE_W'(avg_prod >> RECIP_SHIFT);
            state_in    = ST_CLAMP;
         end
         ST_CLAMP: begin
            num_in   = batavg_pkg::NUM_W'(clamped - lo_ff)
                       * batavg_pkg::NUM_W'(batavg_pkg::PCT_SCALE);
            state_in = ST_PSTART;
         end
         ST_PSTART: begin
            if (range_ok_ff) begin
               state_in = ST_PCT;
            end else begin
               // empty or inverted range reads as zero percent
               pct_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_PCT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = pct_ff;
               rsp_avg_in   = avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= 12'd2482;
         max_ff       <= 12'd3723;
         sum_ff       <= '0;
         slot_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      fill_ff     <= fill_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      span_ff     <= span_in;
      range_ok_ff <= range_ok_in;
      num_ff      <= num_in;
      avg_ff      <= avg_in;
      pct_ff      <= pct_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_avg_ff, rsp_pct_ff};

endmodule
